>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Operation and status codes, beat payloads, cell entry and cell control.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned ID_WIDTH      = 16;
   localparam int unsigned PRIO_WIDTH    = 8;
   localparam int unsigned COUNT_WIDTH   = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_APPEND = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                  operation;
      logic [ID_WIDTH-1:0]     item_id;
      logic [PRIO_WIDTH-1:0]   item_priority;
   } req_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]     out_id;
      logic [PRIO_WIDTH-1:0]   out_priority;
      status_type              status;
      logic [COUNT_WIDTH-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]     id;
      logic [PRIO_WIDTH-1:0]   priority_value;
   } entry_type;

   // Broadcast to every cell each cycle.
   typedef struct packed {
      logic push;         // write a new entry somewhere in the row
      logic by_priority;  // push goes to its sorted place, else to the tail
      logic pop;          // whole row moves one cell toward the head
   } cell_ctrl_type;

endpackage

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry; loads the new entry, its left neighbor or its right
// neighbor, or keeps its own, as the broadcast control says.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT,
   parameter int unsigned INDEX = 0
) (
   input  logic                               clock,
   input  spq_pkg::cell_ctrl_type             ctrl,
   input  spq_pkg::entry_type                 new_entry,
   input  logic [$clog2(DEPTH+1)-1:0]         count,
   input  spq_pkg::entry_type                 left_entry,
   input  logic                               left_want,
   input  spq_pkg::entry_type                 right_entry,
   output spq_pkg::entry_type                 entry,
   output logic                               want
);
   import spq_pkg::*;

   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      match;

   assign occupied = CountWidth'(INDEX) < count;

   // This slot is a legal landing place for the new entry.
   assign match = !occupied
               || (ctrl.by_priority && (new_entry.priority_value < entry_ff.priority_value));

   // Wants the new entry or something right of it. Appends can leave the
   // held entries unsorted, so the flag ripples from the head: only the
   // first matching cell takes the new entry, every cell after it shifts.
   assign want = left_want || match;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (want && !left_want) begin
            entry_in = new_entry;
         end else if (want) begin
            entry_in = left_entry;
         end
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> sv/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue in a row of cells
// Inserts keep (id, priority) entries sorted, smallest priority at the head; appends go to the tail.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one operation per beat: insert by priority,
//   append at tail, remove head, or clear. rsp_ channel returns exactly one
//   beat per request with the removed entry (zero unless a remove
//   succeeded), a status (ok, remove on empty, insert or append dropped
//   when full) and the number of entries held afterward.
//   Latency: the response is registered and valid the cycle after the
//   request beat. Throughput: one request per cycle while the response
//   register can take it; every cell compares its priority with the
//   incoming one in parallel, so an insert needs no search at any depth.
//   A new request is taken while the response register is empty or being
//   drained in the same cycle; when the receiver stalls, req_ready drops
//   and the queue holds its contents.
//   Reset clears the entry count and the response valid; entry contents
//   are not cleared, cells at or beyond the count are never reported.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
   parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_payload
);
   import spq_pkg::*;

   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   // Response register
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_payload_ff;
   rsp_type  rsp_payload_in;

   // Held entry count
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;

   logic                  req_fire;
   logic                  is_full;
   logic                  is_empty;
   cell_ctrl_type         ctrl;
   entry_type             new_entry;
   entry_type             cell_entry [DEPTH];
   logic                  cell_want  [DEPTH];
   logic [CountWidth+COUNT_WIDTH-1:0] count_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = count_ff == CountWidth'(DEPTH);
   assign is_empty  = count_ff == '0;

   assign new_entry.id             = req_payload.item_id;
   assign new_entry.priority_value = req_payload.item_priority;

   always_comb begin
      ctrl.push        = req_fire && !is_full
                      && (req_payload.operation == OP_INSERT
                          || req_payload.operation == OP_APPEND);
      ctrl.by_priority = req_payload.operation == OP_INSERT;
      ctrl.pop         = req_fire && !is_empty && (req_payload.operation == OP_REMOVE);
   end

   // Row of cells: cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_want;
      entry_type right_entry;

      if (i == 0) begin : g_head
         assign left_entry = new_entry;
         assign left_want  = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_want  = cell_want[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell #(
         .DEPTH (DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .count       (count_ff),
         .left_entry  (left_entry),
         .left_want   (left_want),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .want        (cell_want[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end else if (req_fire && req_payload.operation == OP_CLEAR) begin
         count_in = '0;
      end
   end

   // Reported count is the held count taken modulo 32
   assign count_wide = {{COUNT_WIDTH{1'b0}}, count_in};

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (req_fire) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.out_id       = '0;
         rsp_payload_in.out_priority = '0;
         rsp_payload_in.status       = ST_OK;
         rsp_payload_in.entry_count  = count_wide[COUNT_WIDTH-1:0];
         case (req_payload.operation)
            OP_INSERT, OP_APPEND: begin
               if (is_full) begin
                  rsp_payload_in.status = ST_FULL;
               end
            end
            OP_REMOVE: begin
               if (is_empty) begin
                  rsp_payload_in.status = ST_EMPTY;
               end else begin
                  rsp_payload_in.out_id       = cell_entry[0].id;
                  rsp_payload_in.out_priority = cell_entry[0].priority_value;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_priority_queue_core
// Drives insert, append, remove and clear beats with random gaps and
// stalls. A local shadow of the sorted queue predicts each response, and a
// scoreboard checks every response beat in order.
// ----------------------------------------------------------------------------
module tb;
   import spq_pkg::*;

   localparam int unsigned QUEUE_DEPTH   = 16;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // Shadow copy of the queue contents, head at slot 0.
   logic [ID_WIDTH-1:0]   shadow_ids   [QUEUE_DEPTH];
   logic [PRIO_WIDTH-1:0] shadow_prios [QUEUE_DEPTH];
   int unsigned           shadow_count = 0;

   rsp_type     pending_rsps[$];   // predicted responses, oldest first
   int unsigned error_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   sorted_priority_queue_core #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random backpressure at the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Apply one request to the shadow queue and return the response it earns.
   function automatic rsp_type apply_queue_op(req_type r);
      rsp_type     res;
      int unsigned slot;
      int unsigned k;
      bit          placed;
      res = '0;
      res.status = ST_OK;
      case (r.operation)
         OP_INSERT, OP_APPEND: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               slot = shadow_count;
               if (r.operation == OP_INSERT) begin
                  // first entry with a strictly larger priority; ties stay behind
                  placed = 1'b0;
                  for (k = 0; k < shadow_count; k++) begin
                     if (!placed && r.item_priority < shadow_prios[k]) begin
                        slot = k;
                        placed = 1'b1;
                     end
                  end
               end
               for (k = shadow_count; k > slot; k--) begin
                  shadow_ids[k]   = shadow_ids[k-1];
                  shadow_prios[k] = shadow_prios[k-1];
               end
               shadow_ids[slot]   = r.item_id;
               shadow_prios[slot] = r.item_priority;
               shadow_count++;
            end
         end
         OP_REMOVE: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.out_id       = shadow_ids[0];
               res.out_priority = shadow_prios[0];
               for (k = 1; k < shadow_count; k++) begin
                  shadow_ids[k-1]   = shadow_ids[k];
                  shadow_prios[k-1] = shadow_prios[k];
               end
               shadow_count--;
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_WIDTH'(shadow_count);
      return res;
   endfunction

   // Response scoreboard: every accepted response beat against the oldest
   // prediction.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_rsps.size() == 0) begin
            $error("response beat with no request outstanding: %p", rsp_payload);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.out_id !== want.out_id) begin
               $error("out_id: expected %h, got %h", want.out_id, rsp_payload.out_id);
               error_count++;
            end
            if (rsp_payload.out_priority !== want.out_priority) begin
               $error("out_priority: expected %h, got %h",
                      want.out_priority, rsp_payload.out_priority);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_payload.entry_count);
               error_count++;
            end
         end
      end
   end

   // Send one request beat; called and returning at a rising edge.
   task automatic send_request(input op_type op, input logic [ID_WIDTH-1:0] id,
                               input logic [PRIO_WIDTH-1:0] prio);
      req_type beat;
      beat.operation     = op;
      beat.item_id       = id;
      beat.item_priority = prio;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_rsps.push_back(apply_queue_op(beat));
   endtask

   // Hold the sender until every response is back, then let the core settle.
   task automatic wait_queue_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_empty_queue();
      send_request(OP_REMOVE, 16'h0000, 8'h00);
      send_request(OP_CLEAR,  16'hFFFF, 8'hFF);
   endtask

   // Field extremes, a tie, an unsorted append, then drain one past empty.
   task automatic test_sort_order();
      send_request(OP_INSERT, 16'hFFFF, 8'hFF);
      send_request(OP_INSERT, 16'h0000, 8'h00);
      send_request(OP_INSERT, 16'hA5A5, 8'h80);
      send_request(OP_INSERT, 16'h5A5A, 8'h80);   // tie: queues behind A5A5
      send_request(OP_APPEND, 16'h1234, 8'h01);   // tail, out of order
      repeat (6) send_request(OP_REMOVE, 16'h0000, 8'h00);
   endtask

   // Fill to the brim, bounce both kinds of push off it, clear a full queue.
   task automatic test_full_queue();
      int unsigned n;
      for (n = 0; n < QUEUE_DEPTH; n++) begin
         send_request((n % 2) ? OP_APPEND : OP_INSERT,
                      ID_WIDTH'($urandom_range(16'hFFFF)),
                      PRIO_WIDTH'($urandom_range(255)));
      end
      send_request(OP_INSERT, 16'hFFFF, 8'h00);
      send_request(OP_APPEND, 16'h0000, 8'hFF);
      send_request(OP_CLEAR,  16'h0000, 8'h00);
      send_request(OP_REMOVE, 16'h0000, 8'h00);
   endtask

   // Random traffic in runs that lean toward filling or draining, so the
   // queue keeps hitting both full and empty. Priorities cluster at the
   // ends of the range to force ties.
   task automatic test_random_mix(input int unsigned n_items, input int unsigned gap_pct,
                                  input int unsigned stall_pct);
      int unsigned           i;
      int unsigned           run_left;
      int unsigned           roll;
      bit                    filling;
      op_type                op;
      logic [PRIO_WIDTH-1:0] prio;
      send_idle_pct  = gap_pct;
      recv_stall_pct = stall_pct;
      filling  = 1'b1;
      run_left = $urandom_range(60, 20);
      for (i = 0; i < n_items; i++) begin
         if (run_left == 0) begin
            filling  = !filling;
            run_left = $urandom_range(60, 20);
         end
         run_left--;
         if (i == n_items / 2) wait_queue_drained();
         roll = $urandom_range(99);
         if (roll < 2) op = OP_CLEAR;
         else if (roll < (filling ? 50 : 25)) op = OP_INSERT;
         else if (roll < (filling ? 75 : 37)) op = OP_APPEND;
         else op = OP_REMOVE;
         case ($urandom_range(2))
            0: prio = PRIO_WIDTH'($urandom_range(255));
            1: prio = PRIO_WIDTH'($urandom_range(3));
            default: prio = PRIO_WIDTH'(8'hFF - $urandom_range(3));
         endcase
         send_request(op, ID_WIDTH'($urandom_range(16'hFFFF)), prio);
      end
      wait_queue_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  = 35;
      recv_stall_pct = 46;
      test_empty_queue();
      test_sort_order();
      test_full_queue();
      test_random_mix(372, 35, 46);
      test_random_mix(372, 46, 35);
      test_random_mix(372, 0, 0);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
